@@ sv/rmts_pkg.sv @@
// Shared types and constants for the rate-monotonic task selector.
`timescale 1ns / 1ps
package rmts_pkg;

  localparam int MAX_TASKS_DEF       = 16;
  localparam int TIME_WIDTH_BITS_DEF = 16;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_STATE = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_CHECK = 2'd3;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic       wr_add;
    logic       wr_state;
    logic       wr_start;
    logic [5:0] slot;
    logic [7:0] ident;
    logic [1:0] run_state;
    logic [7:0] start_time;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_OUT  = 4'b1000
  } ctrl_state_t;

endpackage

@@ sv/rmts_cell.sv @@
// One task slot: holds its entry and takes part in the running-minimum scan chain.
`timescale 1ns / 1ps
module rmts_cell #(
  parameter int IDX    = 0,
  parameter int TW     = 16,
  parameter int SLOT_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmts_pkg::cell_cmd_t   cmd,
  input  logic [TW-1:0]         duration,
  input  logic [TW-1:0]         period,
  input  logic                  scan_step,
  // chain: running best from the lower neighbour
  input  logic                  prev_found,
  input  logic [TW-1:0]         prev_best,
  input  logic [SLOT_W-1:0]     prev_slot,
  input  logic [7:0]            prev_id,
  output logic                  nxt_found,
  output logic [TW-1:0]         nxt_best,
  output logic [SLOT_W-1:0]     nxt_slot,
  output logic [7:0]            nxt_id,
  output logic                  valid,
  output logic [TW-1:0]         dur_o,
  output logic [7:0]            start_o
);
  import rmts_pkg::*;

  logic          valid_r;
  logic [7:0]    ident_r;
  logic [TW-1:0] dur_r;
  logic [TW-1:0] per_r;
  logic [7:0]    start_r;
  logic [1:0]    rs_r;
  logic          hit;
  logic          take;
  logic          found_r;
  logic [TW-1:0] best_r;
  logic [SLOT_W-1:0] slot_r;
  logic [7:0]    id_r;

  assign hit = (cmd.slot == 6'(IDX));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.wr_add && hit) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_add && hit) begin
      ident_r <= cmd.ident;
      dur_r   <= duration;
      per_r   <= period;
      rs_r    <= ST_READY;
    end else if (cmd.wr_state && hit && valid_r) begin
      rs_r <= cmd.run_state;
    end else if (cmd.wr_start && hit && valid_r) begin
      rs_r    <= ST_RUNNING;
      start_r <= cmd.start_time;
    end
  end

  // strict less keeps the lower slot on a tie
  assign take = valid_r && (rs_r != ST_IDLE) && (!prev_found || per_r < prev_best);

  always_ff @(posedge clk) begin
    if (scan_step) begin
      found_r <= prev_found | take;
      best_r  <= take ? per_r : prev_best;
      slot_r  <= take ? SLOT_W'(IDX) : prev_slot;
      id_r    <= take ? ident_r : prev_id;
    end
  end

  assign nxt_found = found_r;
  assign nxt_best  = best_r;
  assign nxt_slot  = slot_r;
  assign nxt_id    = id_r;
  assign valid     = valid_r;
  assign dur_o     = dur_r;
  assign start_o   = start_r;
endmodule

@@ sv/rate_monotonic_task_selector.sv @@
// A request is taken only in S_IDLE; it then passes through S_SCAN, S_DONE and S_OUT
// before the next request is taken, and its result is registered in S_DONE. The scan
// ripples one cell per cycle along the chain of slot cells.
// Next item is taken while a result waits in the output register; a result still
// waiting when the following scan ends holds the controller until it is taken.
// Reset (synchronous, rst_n low) empties the table and clears the controller.
`timescale 1ns / 1ps
module rate_monotonic_task_selector #(
  parameter int MAX_TASKS       = rmts_pkg::MAX_TASKS_DEF,
  parameter int TIME_WIDTH_BITS = rmts_pkg::TIME_WIDTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[1:0], task_slot[5:2], task_id[13:6], duration[29:14], period[45:30],
  // new_state[47:46], time_now[55:48]
  input  logic [55:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // selected_found[0], selected_slot[4:1], selected_id[12:5], finished[13],
  // table_full[14], added_slot[18:15], zero[23:19]
  output logic [23:0] out_tdata
);
  import rmts_pkg::*;

  localparam int TW     = TIME_WIDTH_BITS;
  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);

  logic [1:0]  f_kind;
  logic [3:0]  f_slot;
  logic [7:0]  f_id;
  logic [15:0] f_dur, f_per;
  logic [1:0]  f_ns;
  logic [7:0]  f_tnow;
  assign f_kind = in_tdata[1:0];
  assign f_slot = in_tdata[5:2];
  assign f_id   = in_tdata[13:6];
  assign f_dur  = in_tdata[29:14];
  assign f_per  = in_tdata[45:30];
  assign f_ns   = in_tdata[47:46];
  assign f_tnow = in_tdata[55:48];

  ctrl_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, step_r, step_nxt;
  logic [1:0]  kind_r;
  logic [3:0]  slot_r;
  logic [7:0]  tnow_r;
  logic        full_r, fin_r;
  logic [3:0]  added_r;
  logic [23:0] odata_r;
  logic        ovalid_r;
  logic        in_fire;

  cell_cmd_t   cmd;
  logic [TW-1:0] dur_w, per_w;

  logic              c_found [MAX_TASKS+1];
  logic [TW-1:0]     c_best  [MAX_TASKS+1];
  logic [SLOT_W-1:0] c_slot  [MAX_TASKS+1];
  logic [7:0]        c_id    [MAX_TASKS+1];
  logic              v_w     [MAX_TASKS];
  logic [TW-1:0]     d_w     [MAX_TASKS];
  logic [7:0]        s_w     [MAX_TASKS];
  logic              scan_step;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // widths of duration/period folded to TIME_WIDTH_BITS
  assign dur_w = TW'(f_dur);
  assign per_w = TW'(f_per);

  always_comb begin
    cmd            = '0;
    cmd.ident      = f_id;
    cmd.run_state  = f_ns;
    cmd.start_time = f_tnow;
    cmd.slot       = {2'b00, f_slot};
    if (in_fire) begin
      unique case (f_kind)
        KIND_ADD: begin
          cmd.wr_add = (count_r < CNT_W'(MAX_TASKS));
          cmd.slot   = 6'(count_r);
        end
        KIND_STATE: cmd.wr_state = (f_ns != 2'd3);
        KIND_START: cmd.wr_start = 1'b1;
        default: ;
      endcase
    end
  end

  assign scan_step   = (state_r == S_SCAN);
  assign c_found[0]  = 1'b0;
  assign c_best[0]   = '0;
  assign c_slot[0]   = '0;
  assign c_id[0]     = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    rmts_cell #(.IDX(g), .TW(TW), .SLOT_W(SLOT_W)) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd), .duration(dur_w), .period(per_w),
      .scan_step(scan_step),
      .prev_found(c_found[g]), .prev_best(c_best[g]),
      .prev_slot(c_slot[g]), .prev_id(c_id[g]),
      .nxt_found(c_found[g+1]), .nxt_best(c_best[g+1]),
      .nxt_slot(c_slot[g+1]), .nxt_id(c_id[g+1]),
      .valid(v_w[g]), .dur_o(d_w[g]), .start_o(s_w[g])
    );
  end

  // finish check on the addressed slot
  logic          usable;
  logic [SLOT_W-1:0] sidx;
  logic [7:0]    diff;
  logic          fin_w;
  always_comb begin
    usable = 1'b0;
    sidx   = '0;
    diff   = '0;
    fin_w  = 1'b0;
    if (32'(slot_r) < MAX_TASKS) begin
      sidx   = SLOT_W'(slot_r);
      usable = v_w[sidx];
    end
    if (usable && tnow_r >= s_w[sidx]) begin
      diff  = tnow_r - s_w[sidx];
      fin_w = (TW'(diff) == d_w[sidx]);
    end
  end

  // the chain ripples one cell per cycle, so the scan steps once for every cell
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        state_nxt = S_SCAN;
        step_nxt  = '0;
        if (cmd.wr_add) count_nxt = count_r + 1'b1;
      end
      S_SCAN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == CNT_W'(MAX_TASKS - 1)) state_nxt = S_DONE;
      end
      S_DONE: if (!ovalid_r || out_tready) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      step_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      if (state_r == S_DONE && (!ovalid_r || out_tready)) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= f_kind;
      slot_r  <= f_slot;
      tnow_r  <= f_tnow;
      full_r  <= (f_kind == KIND_ADD) && !cmd.wr_add;
      added_r <= cmd.wr_add ? 4'(count_r) : 4'd0;
    end
    if (state_r == S_SCAN) fin_r <= (kind_r == KIND_CHECK) && fin_w;
    if (state_r == S_DONE && (!ovalid_r || out_tready)) begin
      odata_r <= {5'd0, added_r, full_r, fin_r, c_id[MAX_TASKS],
                  4'(c_slot[MAX_TASKS]), c_found[MAX_TASKS]};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS)) else $error("task count overflow");
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("controller state not one-hot");
  a_add_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_add |=> count_r == $past(count_r) + 1'b1) else $error("add lost");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("input taken while scanning");
endmodule
